// ===== sv/vrt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared types and constants of the velocity rescaling thermostat.
// ----------------------------------------------------------------------------
package vrt_pkg;

   localparam int VEL_W         = 24;
   localparam int MAX_PARTICLES = 65536;
   localparam int SQ_W          = 2 * VEL_W + 2;
   localparam int DIV_N_W       = 80;
   localparam int DIV_D_W       = 32;

   localparam logic [31:0] ONE_Q8_24 = 32'h0100_0000;

   localparam logic [1:0] REG_TARGET  = 2'd0;
   localparam logic [1:0] REG_MAXSTEP = 2'd1;
   localparam logic [1:0] REG_GRADUAL = 2'd2;
   localparam logic [1:0] REG_DIMS    = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_SAT  = 2'd2;

   typedef struct packed {
      logic                    action;
      logic [15:0]             mass;
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_y;
      logic signed [VEL_W-1:0] vel_z;
      logic                    last_particle;
   } req_type;

   typedef struct packed {
      logic signed [VEL_W-1:0] scaled_x;
      logic signed [VEL_W-1:0] scaled_y;
      logic signed [VEL_W-1:0] scaled_z;
      logic [31:0]             current_temp;
      logic [31:0]             new_temp;
      logic [1:0]              status;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic done;
   } unit_ctl_type;

   typedef enum logic [3:0] {
      S_IDLE, S_MAG, S_PROD, S_TERM, S_ACC,
      S_DIV_E, S_WAIT_E, S_WAIT_S, S_WAIT_R, S_FIN, S_OUT
   } state_type;

endpackage
`default_nettype wire

// ===== sv/vrt_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrt_lane
// One velocity component: magnitude, then square or scale product, saturated.
// ----------------------------------------------------------------------------
module vrt_lane (
   input  wire logic                          clock,
   input  wire logic                          scale_mode,
   input  wire logic [vrt_pkg::VEL_W-1:0]     vel,
   input  wire logic [31:0]                   scale,
   output logic      [vrt_pkg::VEL_W+31:0]    prod,
   output logic      [vrt_pkg::VEL_W-1:0]     scaled,
   output logic                               sat
);
   localparam int W = vrt_pkg::VEL_W;

   logic [W-1:0]  mag_ff, mag_in;
   logic          neg_ff, neg_in;
   logic          negp_ff;
   logic [W+31:0] prod_ff, prod_in;
   logic [31:0]   operand;
   logic [W+7:0]  p, lim;

   always_comb begin
      neg_in  = vel[W-1];
      mag_in  = neg_in ? (W'(0) - vel) : vel;
      operand = scale_mode ? scale : {{(32-W){1'b0}}, mag_ff};
      prod_in = {32'd0, mag_ff} * {{W{1'b0}}, operand};
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      negp_ff <= neg_ff;
      prod_ff <= prod_in;
   end

   // The product is truncated toward zero and clamped to the signed range.
   always_comb begin
      p   = prod_ff[W+31:24];
      lim = negp_ff ? (W+8)'(1) << (W-1) : ((W+8)'(1) << (W-1)) - (W+8)'(1);
      sat = 1'b0;
      if (p > lim) begin
         p   = lim;
         sat = 1'b1;
      end
      scaled = negp_ff ? (W'(0) - p[W-1:0]) : p[W-1:0];
      prod   = prod_ff;
   end

endmodule
`default_nettype wire

// ===== sv/vrt_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrt_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vrt_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [vrt_pkg::DIV_N_W-1:0]   dividend,
   input  wire logic [vrt_pkg::DIV_D_W-1:0]   divisor,
   output logic                               done,
   output logic      [vrt_pkg::DIV_N_W-1:0]   quotient
);
   localparam int NW = vrt_pkg::DIV_N_W;
   localparam int DW = vrt_pkg::DIV_D_W;
   localparam int CW = $clog2(NW);

   logic [NW-1:0] quo_ff, quo_in;
   logic [DW:0]   rem_ff, rem_in, rem_sh;
   logic [DW-1:0] den_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      rem_sh  = {rem_ff[DW-1:0], quo_ff[NW-1]};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (start) begin
         den_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ===== sv/vrt_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrt_sqrt
// Integer square root of a 64-bit word, one root bit per cycle.
// ----------------------------------------------------------------------------
module vrt_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] radicand,
   output logic             done,
   output logic      [31:0] root
);
   logic [63:0] rad_ff, rad_in;
   logic [33:0] rem_ff, rem_in, rem_sh, trial;
   logic [31:0] root_ff, root_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      rem_sh  = {rem_ff[31:0], rad_ff[63:62]};
      trial   = {root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[61:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

// ===== sv/velocity_rescaling_thermostat_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// velocity_rescaling_thermostat_top
// Two-pass velocity rescaling thermostat with three velocity lanes.
// ----------------------------------------------------------------------------
// A request on req_ carries one particle. With action clear it is added to the
// energy sum; only the request flagged last_particle yields a response, after
// the temperature, the new temperature and the scale factor are worked out.
// With action set the velocity is multiplied by the current scale and one
// response is returned for every request.
// One request is handled at a time. After an accumulate request is accepted,
// req_ready stays low through the lane pipeline (magnitude, product), the
// energy term multiply and the accumulate step, so a new request is taken
// only once the last one is through. A scale request shows its response after
// the lane pipeline. The last accumulate request adds up to two 80-step
// divisions (energy by dims times particle count, new by current temperature)
// and a 32-step square root, all one bit per cycle.
// While a response waits, req_ready stays low, so a stalled receiver holds
// the block with the response unchanged on rsp_data.
// Reset clears the sums, sets the scale to one and restores the register
// defaults: target 1.0, unlimited step, gradual mode, three dimensions.
// Registers are written on csr_we and must only change while idle.
// ----------------------------------------------------------------------------
module velocity_rescaling_thermostat_top #(
   parameter int MAX_PARTICLES = vrt_pkg::MAX_PARTICLES
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire vrt_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output vrt_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [31:0]      csr_wdata
);
   localparam int W    = vrt_pkg::VEL_W;
   localparam int SQ_W = vrt_pkg::SQ_W;
   localparam int CNTW = $clog2(MAX_PARTICLES + 1);

   // Configuration registers.
   logic [31:0] target_ff, max_step_ff;
   logic        gradual_ff;
   logic [1:0]  dims_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= 32'h0001_0000;
         max_step_ff <= 32'hFFFF_FFFF;
         gradual_ff  <= 1'b1;
         dims_ff     <= 2'd3;
      end else if (csr_we) begin
         unique case (csr_index)
            vrt_pkg::REG_TARGET:  target_ff   <= csr_wdata;
            vrt_pkg::REG_MAXSTEP: max_step_ff <= csr_wdata;
            vrt_pkg::REG_GRADUAL: gradual_ff  <= csr_wdata[0];
            vrt_pkg::REG_DIMS:    dims_ff     <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   vrt_pkg::state_type state_ff, state_in;
   vrt_pkg::req_type   req_ff;
   vrt_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [63:0]     energy_ff, energy_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic            ovf_ff, ovf_in;
   logic            tsat_ff, tsat_in;
   logic [31:0]     scale_ff, scale_in;
   logic [31:0]     cur_ff, cur_in, new_ff, new_in;
   logic [1:0]      held_st_ff, held_st_in;

   // Lanes: one per velocity component.
   logic [W+31:0] prod_x, prod_y, prod_z;
   logic [W-1:0]  sc_x, sc_y, sc_z;
   logic          sat_x, sat_y, sat_z;

   vrt_lane u_lane_x (.clock(clock), .scale_mode(req_ff.action), .vel(req_ff.vel_x),
                      .scale(scale_ff), .prod(prod_x), .scaled(sc_x), .sat(sat_x));
   vrt_lane u_lane_y (.clock(clock), .scale_mode(req_ff.action), .vel(req_ff.vel_y),
                      .scale(scale_ff), .prod(prod_y), .scaled(sc_y), .sat(sat_y));
   vrt_lane u_lane_z (.clock(clock), .scale_mode(req_ff.action), .vel(req_ff.vel_z),
                      .scale(scale_ff), .prod(prod_z), .scaled(sc_z), .sat(sat_z));

   // Merge of the lane squares, then the mass multiply split in two halves so
   // that the term equals floor(sq * m / 2^16) exactly.
   logic [SQ_W-1:0]  sq_sum;
   logic [SQ_W-1:0]  term_hi_ff;
   logic [15:0]      term_lo_ff;
   logic [SQ_W+15:0] hi_full;
   logic [31:0]      lo_full;
   logic [SQ_W-1:0]  term;
   logic [64:0]      acc_sum;

   always_comb begin
      sq_sum  = SQ_W'(prod_x) + SQ_W'(prod_y) + SQ_W'(prod_z);
      hi_full = {16'd0, sq_sum[SQ_W-1:16]} * {{SQ_W{1'b0}}, req_ff.mass};
      lo_full = sq_sum[15:0] * req_ff.mass;
      term    = term_hi_ff + {{(SQ_W-16){1'b0}}, term_lo_ff};
      acc_sum = {1'b0, energy_ff} + 65'(term);
   end

   always_ff @(posedge clock) begin
      term_hi_ff <= hi_full[SQ_W-1:0];
      term_lo_ff <= lo_full[31:16];
   end

   // Divider, shared by both divisions, and square root.
   logic        div_start, div_done, sq_start, sq_done;
   logic [79:0] div_num, div_quo;
   logic [31:0] div_den, sq_root;
   vrt_pkg::unit_ctl_type div_ctl, sq_ctl;

   vrt_divider u_div (.clock(clock), .reset(reset), .start(div_start),
                      .dividend(div_num), .divisor(div_den), .done(div_done),
                      .quotient(div_quo));
   vrt_sqrt u_sqrt (.clock(clock), .reset(reset), .start(sq_start),
                    .radicand(div_quo[63:0]), .done(sq_done), .root(sq_root));

   assign div_ctl = '{start: div_start, done: div_done};
   assign sq_ctl  = '{start: sq_start, done: sq_done};

   // Divisor dims * count, with dimensions below two taken as two.
   logic [18:0] pdiv;
   logic [31:0] t_val;
   logic        t_sat;
   logic [33:0] diff, ms;
   logic [31:0] nw;

   always_comb begin
      pdiv = {1'b0, 18'(count_ff) << 1} +
             ((dims_ff == 2'd3) ? 19'(count_ff) : 19'd0);
      t_sat = (pdiv != 19'd0) && (div_quo[63:40] != 24'd0);
      t_val = (pdiv == 19'd0) ? 32'd0 : (t_sat ? 32'hFFFF_FFFF : div_quo[39:8]);
      diff  = {2'b00, target_ff} - {2'b00, t_val};
      ms    = {2'b00, max_step_ff};
      nw    = target_ff;
      if (gradual_ff) begin
         if ($signed(diff) > $signed(ms)) begin
            nw = t_val + max_step_ff;
         end else if ($signed(diff) < -$signed(ms)) begin
            nw = t_val - max_step_ff;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      energy_in    = energy_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      tsat_in      = tsat_ff;
      scale_in     = scale_ff;
      cur_in       = cur_ff;
      new_in       = new_ff;
      held_st_in   = held_st_ff;
      div_start    = 1'b0;
      sq_start     = 1'b0;
      div_num      = {16'd0, energy_ff};
      div_den      = {13'd0, pdiv};
      req_ready    = (state_ff == vrt_pkg::S_IDLE);

      unique case (state_ff)
         vrt_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = vrt_pkg::S_MAG;
            end
         end
         vrt_pkg::S_MAG:  state_in = vrt_pkg::S_PROD;
         vrt_pkg::S_PROD: state_in = vrt_pkg::S_TERM;
         vrt_pkg::S_TERM: begin
            if (req_ff.action) begin
               rsp_in.scaled_x     = sc_x;
               rsp_in.scaled_y     = sc_y;
               rsp_in.scaled_z     = sc_z;
               rsp_in.current_temp = cur_ff;
               rsp_in.new_temp     = new_ff;
               rsp_in.status = (sat_x | sat_y | sat_z) ? vrt_pkg::ST_SAT : held_st_ff;
               rsp_valid_in  = 1'b1;
               state_in      = vrt_pkg::S_OUT;
            end else begin
               state_in = vrt_pkg::S_ACC;
            end
         end
         vrt_pkg::S_ACC: begin
            if (count_ff >= CNTW'(MAX_PARTICLES)) begin
               ovf_in = 1'b1;
            end else begin
               count_in = count_ff + CNTW'(1);
               if (acc_sum[64]) begin
                  energy_in = '1;
                  ovf_in    = 1'b1;
               end else begin
                  energy_in = acc_sum[63:0];
               end
            end
            state_in = req_ff.last_particle ? vrt_pkg::S_DIV_E : vrt_pkg::S_IDLE;
         end
         vrt_pkg::S_DIV_E: begin
            div_start = 1'b1;
            state_in  = vrt_pkg::S_WAIT_E;
         end
         vrt_pkg::S_WAIT_E: begin
            if (div_ctl.done) begin
               cur_in  = t_val;
               new_in  = nw;
               tsat_in = t_sat;
               if (t_val == 32'd0) begin
                  scale_in = vrt_pkg::ONE_Q8_24;
                  state_in = vrt_pkg::S_FIN;
               end else begin
                  div_start = 1'b1;
                  div_num   = {nw, 48'd0};
                  div_den   = t_val;
                  state_in  = vrt_pkg::S_WAIT_S;
               end
            end
         end
         vrt_pkg::S_WAIT_S: begin
            if (div_ctl.done) begin
               if (div_quo[79:64] != 16'd0) begin
                  scale_in = 32'hFFFF_FFFF;
                  tsat_in  = 1'b1;
                  state_in = vrt_pkg::S_FIN;
               end else begin
                  sq_start = 1'b1;
                  state_in = vrt_pkg::S_WAIT_R;
               end
            end
         end
         vrt_pkg::S_WAIT_R: begin
            if (sq_ctl.done) begin
               scale_in = sq_root;
               state_in = vrt_pkg::S_FIN;
            end
         end
         vrt_pkg::S_FIN: begin
            if (ovf_ff || tsat_ff) begin
               held_st_in = vrt_pkg::ST_SAT;
            end else if (cur_ff == 32'd0) begin
               held_st_in = vrt_pkg::ST_ZERO;
            end else begin
               held_st_in = vrt_pkg::ST_OK;
            end
            rsp_in.scaled_x     = '0;
            rsp_in.scaled_y     = '0;
            rsp_in.scaled_z     = '0;
            rsp_in.current_temp = cur_ff;
            rsp_in.new_temp     = new_ff;
            rsp_in.status       = held_st_in;
            rsp_valid_in        = 1'b1;
            energy_in           = '0;
            count_in            = '0;
            ovf_in              = 1'b0;
            tsat_in             = 1'b0;
            state_in            = vrt_pkg::S_OUT;
         end
         vrt_pkg::S_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = vrt_pkg::S_IDLE;
            end
         end
         default: state_in = vrt_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vrt_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         energy_ff    <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         tsat_ff      <= 1'b0;
         scale_ff     <= vrt_pkg::ONE_Q8_24;
         cur_ff       <= '0;
         new_ff       <= '0;
         held_st_ff   <= vrt_pkg::ST_OK;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         energy_ff    <= energy_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         tsat_ff      <= tsat_in;
         scale_ff     <= scale_in;
         cur_ff       <= cur_in;
         new_ff       <= new_in;
         held_st_ff   <= held_st_in;
      end
      rsp_ff <= rsp_in;
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the velocity rescaling thermostat.
// ----------------------------------------------------------------------------
// Particle requests are driven over the valid/ready request channel. A local
// thermostat model works out every expected response, and a monitor compares
// each accepted response field by field against the oldest expected entry.
// Register changes are made only while the block is idle.
// ----------------------------------------------------------------------------
module tb;

   localparam int VEL_W = vrt_pkg::VEL_W;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   vrt_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   vrt_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = vrt_pkg::REG_TARGET;
   logic [31:0] csr_wdata = '0;

   localparam logic ACT_ACCUM = 1'b0;
   localparam logic ACT_SCALE = 1'b1;

   velocity_rescaling_thermostat_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // The clock period is 12 ns.
   always #6 clock = ~clock;

   // Shadow of the register file and of the thermostat state.
   logic [31:0] m_target, m_step;
   logic        m_gradual;
   logic [1:0]  m_dims;
   logic [63:0] m_energy;
   int unsigned m_count;
   logic [31:0] m_scale, m_cur, m_new;
   logic [1:0]  m_status;
   bit          m_over;

   vrt_pkg::rsp_type expected_rsp[$];
   int errors = 0;
   int send_idle_pct = 0;   // chance in a hundred that the sender idles
   int recv_idle_pct = 0;   // chance in a hundred that the receiver stalls

   function automatic logic [63:0] vel_mag(logic [VEL_W-1:0] v);
      logic [63:0] x;
      x = {40'd0, v};
      return v[VEL_W-1] ? (64'd1 << VEL_W) - x : x;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Scales one component, clamping to the signed range and flagging it.
   function automatic logic [VEL_W-1:0] scale_vel(logic [VEL_W-1:0] v, inout bit sat);
      logic [63:0] mag, p, lim;
      mag = vel_mag(v);
      p = (mag * {32'd0, m_scale}) >> 24;
      lim = v[VEL_W-1] ? (64'd1 << (VEL_W-1)) : (64'd1 << (VEL_W-1)) - 1;
      if (p > lim) begin
         p = lim;
         sat = 1;
      end
      return v[VEL_W-1] ? VEL_W'((64'd1 << VEL_W) - p) : VEL_W'(p);
   endfunction

   // End of the accumulate pass: temperature, new temperature and scale.
   task automatic close_pass();
      logic [63:0] dv, t, q, rem;
      longint diff;
      bit sat;
      logic [1:0] st;
      sat = m_over;
      dv = (m_dims < 2 ? 64'd2 : 64'(m_dims)) * 64'(m_count);
      t = dv != 0 ? (m_energy / dv) >> 8 : 64'd0;
      if (t > 64'hFFFF_FFFF) begin
         t = 64'hFFFF_FFFF;
         sat = 1;
      end
      m_cur = t[31:0];
      if (m_gradual) begin
         diff = longint'({32'd0, m_target}) - longint'({32'd0, m_cur});
         if (diff > longint'({32'd0, m_step})) m_new = m_cur + m_step;
         else if (diff < -longint'({32'd0, m_step})) m_new = m_cur - m_step;
         else m_new = m_target;
      end else begin
         m_new = m_target;
      end
      st = vrt_pkg::ST_OK;
      if (m_cur == 0) begin
         m_scale = vrt_pkg::ONE_Q8_24;
         st = vrt_pkg::ST_ZERO;
      end else if (m_new / m_cur >= 65536) begin
         m_scale = 32'hFFFF_FFFF;
         sat = 1;
      end else begin
         q = m_new / m_cur;
         rem = m_new % m_cur;
         for (int i = 0; i < 48; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= m_cur) begin
               rem = rem - m_cur;
               q[0] = 1'b1;
            end
         end
         m_scale = int_sqrt(q);
      end
      m_status = sat ? vrt_pkg::ST_SAT : st;
      m_energy = 0;
      m_count = 0;
      m_over = 0;
   endtask

   // Predicts the response of one accepted request, if it has one.
   task automatic predict_thermostat(vrt_pkg::req_type r);
      vrt_pkg::rsp_type e;
      logic [63:0] sq, term;
      bit sat;
      if (r.action == ACT_ACCUM) begin
         if (m_count >= vrt_pkg::MAX_PARTICLES) begin
            m_over = 1;
         end else begin
            sq = vel_mag(r.vel_x) * vel_mag(r.vel_x) + vel_mag(r.vel_y) * vel_mag(r.vel_y)
               + vel_mag(r.vel_z) * vel_mag(r.vel_z);
            term = (sq >> 16) * r.mass + (((sq & 64'hFFFF) * r.mass) >> 16);
            if (m_energy > ~64'd0 - term) begin
               m_energy = ~64'd0;
               m_over = 1;
            end else begin
               m_energy = m_energy + term;
            end
            m_count++;
         end
         if (!r.last_particle) return;
         close_pass();
         e = '0;
         e.current_temp = m_cur;
         e.new_temp = m_new;
         e.status = m_status;
      end else begin
         sat = 0;
         e.scaled_x = scale_vel(r.vel_x, sat);
         e.scaled_y = scale_vel(r.vel_y, sat);
         e.scaled_z = scale_vel(r.vel_z, sat);
         e.current_temp = m_cur;
         e.new_temp = m_new;
         e.status = sat ? vrt_pkg::ST_SAT : m_status;
      end
      expected_rsp.push_back(e);
   endtask

   // Sends one request, idling beforehand at random, and predicts it. Valid
   // stays high after acceptance until the next request or an idle cycle.
   task automatic send_request(vrt_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      predict_thermostat(r);
   endtask

   // Waits until every expected response has arrived, plus the slack a
   // plain accumulate request might still be using.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         vrt_pkg::REG_TARGET:  m_target = val;
         vrt_pkg::REG_MAXSTEP: m_step = val;
         vrt_pkg::REG_GRADUAL: m_gradual = val[0];
         default:              m_dims = val[1:0];
      endcase
   endtask

   function automatic vrt_pkg::req_type particle(logic act, logic [15:0] m,
                                                 logic [VEL_W-1:0] x, logic [VEL_W-1:0] y,
                                                 logic [VEL_W-1:0] z, logic l);
      vrt_pkg::req_type r;
      r.action = act;
      r.mass = m;
      r.vel_x = x;
      r.vel_y = y;
      r.vel_z = z;
      r.last_particle = l;
      return r;
   endfunction

   // Velocities are usually moderate so that temperatures stay sensible,
   // but now and then they span the whole field.
   function automatic logic [VEL_W-1:0] rand_vel();
      if ($urandom_range(9) == 0) return VEL_W'($urandom);
      return VEL_W'($signed($urandom_range(262143)) - 131072);
   endfunction

   function automatic vrt_pkg::req_type rand_particle(logic act, logic l);
      return particle(act, 16'($urandom), rand_vel(), rand_vel(), rand_vel(),
                      $urandom_range(1) ? l : (act ? 1'($urandom) : l));
   endfunction

   // Directed corners: before any pass, zero temperature, extremes of the
   // fields, a temperature above the target, last flag on scaling.
   task automatic test_directed();
      send_request(particle(ACT_SCALE, 16'hFFFF, 24'h7FFFFF, 24'h800000, 24'h000001, 1'b1));
      send_request(particle(ACT_ACCUM, 16'h0000, 24'h7FFFFF, 24'h800000, 24'h0, 1'b1));
      send_request(particle(ACT_SCALE, 16'h0, 24'h123456, 24'hFEDCBA, 24'h0, 1'b0));
      send_request(particle(ACT_ACCUM, 16'hFFFF, 24'h800000, 24'h800000, 24'h800000, 1'b0));
      send_request(particle(ACT_ACCUM, 16'hFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b1));
      send_request(particle(ACT_SCALE, 16'h1, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 1'b0));
      // A tiny energy works out to a zero temperature, so the scale is one.
      send_request(particle(ACT_ACCUM, 16'h0001, 24'h000100, 24'h0, 24'h0, 1'b1));
      send_request(particle(ACT_SCALE, 16'h0, 24'h000001, 24'hFFFFFF, 24'h400000, 1'b0));
      send_request(particle(ACT_ACCUM, 16'h0100, 24'h010000, 24'hFF0000, 24'h0, 1'b0));
      send_request(particle(ACT_ACCUM, 16'h0200, 24'h020000, 24'h0, 24'h010000, 1'b1));
      send_request(particle(ACT_SCALE, 16'h0, 24'h010000, 24'hFF0000, 24'h7FFFFF, 1'b0));
      drain();
   endtask

   // Random passes under one register setting.
   task automatic test_passes(int passes);
      int n;
      repeat (passes) begin
         n = $urandom_range(6, 1);
         for (int i = 0; i < n; i++) send_request(rand_particle(ACT_ACCUM, i == n - 1));
         repeat ($urandom_range(5, 1)) send_request(rand_particle(ACT_SCALE, 1'b0));
      end
      drain();
   endtask

   // Several register settings, extremes among them.
   task automatic test_settings(int passes);
      write_reg(vrt_pkg::REG_GRADUAL, 32'd0);
      write_reg(vrt_pkg::REG_DIMS, 32'd2);
      write_reg(vrt_pkg::REG_TARGET, 32'h0000_8000);
      test_passes(passes);
      write_reg(vrt_pkg::REG_GRADUAL, 32'd1);
      write_reg(vrt_pkg::REG_MAXSTEP, 32'd0);
      write_reg(vrt_pkg::REG_TARGET, 32'hFFFF_FFFF);
      test_passes(passes);
      write_reg(vrt_pkg::REG_MAXSTEP, 32'h0000_4000);
      write_reg(vrt_pkg::REG_TARGET, 32'd0);
      write_reg(vrt_pkg::REG_DIMS, 32'd0);
      test_passes(passes);
      write_reg(vrt_pkg::REG_DIMS, 32'd1);
      write_reg(vrt_pkg::REG_MAXSTEP, $urandom);
      write_reg(vrt_pkg::REG_TARGET, $urandom_range(32'h0008_0000));
      test_passes(passes);
      write_reg(vrt_pkg::REG_DIMS, 32'd3);
      write_reg(vrt_pkg::REG_MAXSTEP, 32'hFFFF_FFFF);
      write_reg(vrt_pkg::REG_TARGET, 32'h0001_0000);
      test_passes(passes);
   endtask

   // Response monitor: samples at the clock edge and compares each accepted
   // response with the oldest expected one.
   always @(posedge clock) begin
      vrt_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_data);
            errors++;
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_data.scaled_x !== e.scaled_x) begin
               $display("%0t: scaled_x expected %h actual %h", $time, e.scaled_x,
                        rsp_data.scaled_x);
               errors++;
            end
            if (rsp_data.scaled_y !== e.scaled_y) begin
               $display("%0t: scaled_y expected %h actual %h", $time, e.scaled_y,
                        rsp_data.scaled_y);
               errors++;
            end
            if (rsp_data.scaled_z !== e.scaled_z) begin
               $display("%0t: scaled_z expected %h actual %h", $time, e.scaled_z,
                        rsp_data.scaled_z);
               errors++;
            end
            if (rsp_data.current_temp !== e.current_temp) begin
               $display("%0t: current_temp expected %h actual %h", $time, e.current_temp,
                        rsp_data.current_temp);
               errors++;
            end
            if (rsp_data.new_temp !== e.new_temp) begin
               $display("%0t: new_temp expected %h actual %h", $time, e.new_temp,
                        rsp_data.new_temp);
               errors++;
            end
            if (rsp_data.status !== e.status) begin
               $display("%0t: status expected %h actual %h", $time, e.status,
                        rsp_data.status);
               errors++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Stimulus runs through the phases of idling in turn.
   initial begin
      m_target = 32'h0001_0000;
      m_step = 32'hFFFF_FFFF;
      m_gradual = 1'b1;
      m_dims = 2'd3;
      m_energy = 0;
      m_count = 0;
      m_scale = vrt_pkg::ONE_Q8_24;
      m_cur = 0;
      m_new = 0;
      m_status = vrt_pkg::ST_OK;
      m_over = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 7;
      recv_idle_pct = 68;
      test_directed();
      test_settings(4);
      send_idle_pct = 68;
      recv_idle_pct = 7;
      test_settings(4);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_settings(6);
      drain();
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end
endmodule

// ===== velocity_rescaling_thermostat_top.f =====
sv/vrt_pkg.sv
sv/vrt_lane.sv
sv/vrt_divider.sv
sv/vrt_sqrt.sv
sv/velocity_rescaling_thermostat_top.sv
verif/tb.sv
